// ----- design/pbrs_pkg.sv -----
// ---------------------------------------------------------------------------
// pbrs_pkg - shared types for the priority bitmap ready scheduler
// Opcodes, result status codes, controller states, command bundle and the
// lowest-set-bit search used for dispatch.
// ---------------------------------------------------------------------------
package pbrs_pkg;

  localparam int TASK_W = 6;
  localparam int PRIO_W = 5;
  localparam int OP_W   = 2;
  localparam int STAT_W = 2;
  localparam int MAP_W  = 32;

  localparam int NUM_PRIORITIES_DEF = 32;
  localparam int NUM_TASKS_DEF      = 64;
  localparam int QUEUE_DEPTH_DEF    = 64;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH     = 2'd0,
    OP_DISPATCH = 2'd1,
    OP_TAKE     = 2'd2,
    OP_RETURN   = 2'd3
  } opcode_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_e;

  typedef struct packed {
    logic exec;  // execute the accepted request
    logic load;  // move pending result into the output register
  } pbrs_cmd_t;

  // Lowest set bit: pick the lowest non-empty byte, then the bit inside it.
  function automatic logic [PRIO_W-1:0] lowest_set(input logic [MAP_W-1:0] v);
    logic [1:0] grp;
    logic [2:0] pos;
    logic [7:0] sub;
    grp = 2'd3;
    for (int g = 3; g >= 0; g--) begin
      if (|v[g*8 +: 8]) grp = 2'(g);
    end
    sub = v[grp*8 +: 8];
    pos = 3'd7;
    for (int b = 7; b >= 0; b--) begin
      if (sub[b]) pos = 3'(b);
    end
    return {grp, pos};
  endfunction

endpackage

// ----- design/pbrs_ram.sv -----
// ---------------------------------------------------------------------------
// pbrs_ram - generic single-write, single-read RAM
// One write port and one read port, read data registered on read enable.
// ---------------------------------------------------------------------------
module pbrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/pbrs_ctrl.sv -----
// ---------------------------------------------------------------------------
// pbrs_ctrl - request sequencer
// Accepts a request in IDLE, waits in READ for memory read data, then
// loads the output register once it is free.
// ---------------------------------------------------------------------------
module pbrs_ctrl
  import pbrs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output pbrs_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_READ;
      end
      S_READ: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o  = 1'b1;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.exec = in_valid_i;
      end
      S_READ: begin
        cmd_o.load = out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- design/pbrs_dp.sv -----
// ---------------------------------------------------------------------------
// pbrs_dp - scheduler datapath
// Ready bitmap, per-level FIFO pointers, ready and free stores, the halt
// register and the result registers.
// ---------------------------------------------------------------------------
module pbrs_dp
  import pbrs_pkg::*;
#(
  parameter int NUM_PRIORITIES = NUM_PRIORITIES_DEF,
  parameter int NUM_TASKS      = NUM_TASKS_DEF,
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pbrs_cmd_t         cmd_i,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic [OP_W-1:0]   opcode_i,
  input  logic [TASK_W-1:0] task_index_i,
  input  logic [PRIO_W-1:0] priority_req_i,
  output logic [STAT_W-1:0] status_o,
  output logic [TASK_W-1:0] result_task_o,
  output logic [PRIO_W-1:0] result_priority_o,
  output logic              any_ready_o
);

  localparam int LVL_W = $clog2(NUM_PRIORITIES);
  localparam int RP_W  = $clog2(QUEUE_DEPTH);
  localparam int RC_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int RA_W  = $clog2(NUM_PRIORITIES * QUEUE_DEPTH);
  localparam int FP_W  = $clog2(NUM_TASKS);
  localparam int FC_W  = $clog2(NUM_TASKS + 1);

  // Halt register
  logic halted_q;

  // Ready queues
  logic [NUM_PRIORITIES-1:0] bitmap_q, bitmap_d;
  logic [RP_W-1:0]           rhead_q [NUM_PRIORITIES];
  logic [RP_W-1:0]           rtail_q [NUM_PRIORITIES];
  logic [RC_W-1:0]           rcnt_q  [NUM_PRIORITIES];
  logic [RP_W-1:0]           rhead_d, rtail_d;
  logic [RC_W-1:0]           rcnt_d;
  logic                      rptr_upd;

  // Free list
  logic [FP_W-1:0]      fhead_q, fhead_d, ftail_q, ftail_d;
  logic [FC_W-1:0]      fcnt_q, fcnt_d;
  logic [NUM_TASKS-1:0] fwr_q, fwr_d;

  // Pending result of the request in flight
  logic [STAT_W-1:0] pstat_q, pstat_d;
  logic [PRIO_W-1:0] pprio_q, pprio_d;
  logic              pany_q, pany_d;
  logic              puse_ready_q, puse_ready_d;
  logic              puse_free_q, puse_free_d;
  logic              pfree_hit_q, pfree_hit_d;
  logic [TASK_W-1:0] pfree_init_q, pfree_init_d;

  // Output register
  logic [STAT_W-1:0] ostat_q;
  logic [TASK_W-1:0] otask_q, otask_d;
  logic [PRIO_W-1:0] oprio_q;
  logic              oany_q;

  // Lookup
  logic [PRIO_W-1:0]     lv_full;
  logic [LVL_W-1:0]      lv, sel;
  logic                  push_oor;
  logic [RP_W-1:0]       rhead_sel, rtail_sel;
  logic [RC_W-1:0]       rcnt_sel;
  logic [FP_W+TASK_W-1:0] fhead_ext;

  // Memory ports
  logic              rram_we, rram_re, fram_we, fram_re;
  logic [RA_W-1:0]   rram_waddr, rram_raddr;
  logic [TASK_W-1:0] rram_rdata, fram_rdata;

  assign lv_full   = lowest_set(MAP_W'(bitmap_q));
  assign lv        = lv_full[LVL_W-1:0];
  assign push_oor  = 32'(priority_req_i) >= NUM_PRIORITIES;
  assign sel       = (opcode_e'(opcode_i) == OP_PUSH) ? priority_req_i[LVL_W-1:0] : lv;
  assign rhead_sel = rhead_q[sel];
  assign rtail_sel = rtail_q[sel];
  assign rcnt_sel  = rcnt_q[sel];
  assign fhead_ext = {{TASK_W{1'b0}}, fhead_q};

  assign rram_waddr = RA_W'(RA_W'(sel) * RA_W'(QUEUE_DEPTH) + RA_W'(rtail_sel));
  assign rram_raddr = RA_W'(RA_W'(sel) * RA_W'(QUEUE_DEPTH) + RA_W'(rhead_sel));

  always_comb begin
    bitmap_d     = bitmap_q;
    rhead_d      = rhead_sel;
    rtail_d      = rtail_sel;
    rcnt_d       = rcnt_sel;
    rptr_upd     = 1'b0;
    fhead_d      = fhead_q;
    ftail_d      = ftail_q;
    fcnt_d       = fcnt_q;
    fwr_d        = fwr_q;
    rram_we      = 1'b0;
    rram_re      = 1'b0;
    fram_we      = 1'b0;
    fram_re      = 1'b0;
    pstat_d      = STAT_DONE;
    pprio_d      = '0;
    puse_ready_d = 1'b0;
    puse_free_d  = 1'b0;
    pfree_hit_d  = fwr_q[fhead_q];
    pfree_init_d = fhead_ext[TASK_W-1:0];
    if (cmd_i.exec) begin
      case (opcode_e'(opcode_i))
        OP_PUSH: begin
          if (push_oor || rcnt_sel == RC_W'(QUEUE_DEPTH)) begin
            pstat_d = STAT_FULL;
          end else begin
            rram_we  = 1'b1;
            rptr_upd = 1'b1;
            rtail_d  = (rtail_sel == RP_W'(QUEUE_DEPTH - 1)) ? '0 : rtail_sel + RP_W'(1);
            rcnt_d   = rcnt_sel + RC_W'(1);
            bitmap_d[sel] = 1'b1;
          end
        end
        OP_DISPATCH: begin
          if (bitmap_q == '0 || halted_q) begin
            pstat_d = STAT_EMPTY;
          end else begin
            rram_re      = 1'b1;
            rptr_upd     = 1'b1;
            puse_ready_d = 1'b1;
            pprio_d      = PRIO_W'(lv);
            rhead_d = (rhead_sel == RP_W'(QUEUE_DEPTH - 1)) ? '0 : rhead_sel + RP_W'(1);
            if (rcnt_sel != '0) rcnt_d = rcnt_sel - RC_W'(1);
            if (rcnt_d == '0) bitmap_d[sel] = 1'b0;
          end
        end
        OP_TAKE: begin
          if (fcnt_q == '0) begin
            pstat_d = STAT_EMPTY;
          end else begin
            fram_re     = 1'b1;
            puse_free_d = 1'b1;
            fhead_d = (fhead_q == FP_W'(NUM_TASKS - 1)) ? '0 : fhead_q + FP_W'(1);
            fcnt_d  = fcnt_q - FC_W'(1);
          end
        end
        OP_RETURN: begin
          if (fcnt_q == FC_W'(NUM_TASKS)) begin
            pstat_d = STAT_FULL;
          end else begin
            fram_we        = 1'b1;
            fwr_d[ftail_q] = 1'b1;
            ftail_d = (ftail_q == FP_W'(NUM_TASKS - 1)) ? '0 : ftail_q + FP_W'(1);
            fcnt_d  = fcnt_q + FC_W'(1);
          end
        end
        default: pstat_d = STAT_DONE;
      endcase
    end
    pany_d = bitmap_d != '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      halted_q <= 1'b0;
      bitmap_q <= '0;
      fhead_q  <= '0;
      ftail_q  <= '0;
      fcnt_q   <= FC_W'(NUM_TASKS);
      fwr_q    <= '0;
      for (int i = 0; i < NUM_PRIORITIES; i++) begin
        rhead_q[i] <= '0;
        rtail_q[i] <= '0;
        rcnt_q[i]  <= '0;
      end
    end else begin
      if (cfg_we_i) halted_q <= cfg_wdata_i;
      bitmap_q <= bitmap_d;
      fhead_q  <= fhead_d;
      ftail_q  <= ftail_d;
      fcnt_q   <= fcnt_d;
      fwr_q    <= fwr_d;
      if (rptr_upd) begin
        rhead_q[sel] <= rhead_d;
        rtail_q[sel] <= rtail_d;
        rcnt_q[sel]  <= rcnt_d;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      pstat_q      <= pstat_d;
      pprio_q      <= pprio_d;
      pany_q       <= pany_d;
      puse_ready_q <= puse_ready_d;
      puse_free_q  <= puse_free_d;
      pfree_hit_q  <= pfree_hit_d;
      pfree_init_q <= pfree_init_d;
    end
    if (cmd_i.load) begin
      ostat_q <= pstat_q;
      otask_q <= otask_d;
      oprio_q <= pprio_q;
      oany_q  <= pany_q;
    end
  end

  always_comb begin
    if (puse_ready_q) begin
      otask_d = rram_rdata;
    end else if (puse_free_q) begin
      otask_d = pfree_hit_q ? fram_rdata : pfree_init_q;
    end else begin
      otask_d = '0;
    end
  end

  pbrs_ram #(
    .WIDTH (TASK_W),
    .DEPTH (NUM_PRIORITIES * QUEUE_DEPTH)
  ) u_ready_ram (
    .clk_i   (clk_i),
    .we_i    (rram_we),
    .waddr_i (rram_waddr),
    .wdata_i (task_index_i),
    .re_i    (rram_re),
    .raddr_i (rram_raddr),
    .rdata_o (rram_rdata)
  );

  pbrs_ram #(
    .WIDTH (TASK_W),
    .DEPTH (NUM_TASKS)
  ) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (fram_we),
    .waddr_i (ftail_q),
    .wdata_i (task_index_i),
    .re_i    (fram_re),
    .raddr_i (fhead_q),
    .rdata_o (fram_rdata)
  );

  assign status_o          = ostat_q;
  assign result_task_o     = otask_q;
  assign result_priority_o = oprio_q;
  assign any_ready_o       = oany_q;

endmodule

// ----- design/priority_bitmap_ready_scheduler_unit.sv -----
// ---------------------------------------------------------------------------
// priority_bitmap_ready_scheduler_unit - bitmap priority task scheduler
// Per-level ready FIFOs with a non-empty bitmap, plus a free task list.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid_i / in_stall_o): opcode_i selects push ready,
//   dispatch next, take free or return free; task_index_i and priority_req_i
//   carry the operands. A transfer happens when valid is high and stall low.
//   Result channel (out_valid_o / out_stall_i): one result per request with
//   status, task, priority and the any-ready flag after the request.
//   Config: cfg_we_i writes cfg_wdata_i into the halt bit; while set,
//   dispatch requests return status "empty". Write it only while idle.
// Timing:
//   A request is executed in its transfer cycle (pointer and bitmap update,
//   store access issued); the registered store data then goes to the output
//   register when it is free; no new request is taken before that load.
//   The request port reopens while a result still waits in the output
//   register; a further result stalls the sequencer until the receiver
//   takes the waiting one.
// Reset:
//   All queues empty, bitmap clear, free list full with task i at slot i
//   (per-slot written bits stand in for the initial contents, so there is
//   no clearing pass), halt bit clear.
// ---------------------------------------------------------------------------
module priority_bitmap_ready_scheduler_unit
  import pbrs_pkg::*;
#(
  parameter int NUM_PRIORITIES = NUM_PRIORITIES_DEF,
  parameter int NUM_TASKS      = NUM_TASKS_DEF,
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  // request channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [OP_W-1:0]   opcode_i,
  input  logic [TASK_W-1:0] task_index_i,
  input  logic [PRIO_W-1:0] priority_req_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [STAT_W-1:0] status_o,
  output logic [TASK_W-1:0] result_task_o,
  output logic [PRIO_W-1:0] result_priority_o,
  output logic              any_ready_o
);

  pbrs_cmd_t cmd;

  // sequencer: accept, wait for store read, load output register
  pbrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // queues, stores and result registers
  pbrs_dp #(
    .NUM_PRIORITIES (NUM_PRIORITIES),
    .NUM_TASKS      (NUM_TASKS),
    .QUEUE_DEPTH    (QUEUE_DEPTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .opcode_i          (opcode_i),
    .task_index_i      (task_index_i),
    .priority_req_i    (priority_req_i),
    .status_o          (status_o),
    .result_task_o     (result_task_o),
    .result_priority_o (result_priority_o),
    .any_ready_o       (any_ready_o)
  );

  // a transfer in closes the request port for the following cycle
  a_stall_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request port open right after a transfer");

  // failed requests report no task and no level
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != STAT_DONE) |->
      (result_task_o == '0 && result_priority_o == '0))
    else $error("nonzero task or level on a failed request");

  // a dispatched level always exists
  a_prio_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(result_priority_o) < NUM_PRIORITIES))
    else $error("dispatched level out of range");

  // a dispatch from a nonzero level leaves the output nonempty only if work
  // existed; a nonzero level implies the request succeeded
  a_prio_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_priority_o != '0) |-> (status_o == STAT_DONE))
    else $error("level reported on a failed request");

endmodule

// ----- dv/priority_bitmap_ready_scheduler_unit_test.sv -----
// ---------------------------------------------------------------------------
// priority_bitmap_ready_scheduler_unit_test - scheduler request/result checker
// Drives push, dispatch, take-free and return-free requests into the
// scheduler, keeps a cycle-free software copy of the ready queues, bitmap,
// free list and halt bit, and checks every result transfer field by field in
// order. Covers the corner cases, the halt register, random traffic with
// idle and stall bursts, and a long receiver hold-off.
// ---------------------------------------------------------------------------
module priority_bitmap_ready_scheduler_unit_test;
  import pbrs_pkg::*;

  localparam int NUM_LEVELS     = NUM_PRIORITIES_DEF;
  localparam int NUM_TASK_IDS   = NUM_TASKS_DEF;
  localparam int LEVEL_DEPTH    = QUEUE_DEPTH_DEF;
  localparam int HOLD_CYCLES    = 60;    // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer
  localparam int SETTLE_CYCLES  = 4;     // pipeline settle time, with margin

  // One result as the scheduler should report it.
  typedef struct packed {
    status_e           status;
    logic [TASK_W-1:0] task_id;
    logic [PRIO_W-1:0] level;
    logic              any_ready;
  } sched_result_t;

  // Traffic shapes for the random part.
  typedef enum int {
    MIX_BALANCED,  // all operations alike
    MIX_FILL,      // push heavy, aimed at two levels so queues run full
    MIX_DRAIN,     // dispatch heavy, empties the queues
    MIX_FREE       // free list take/return churn
  } mix_e;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic              cfg_wdata_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [OP_W-1:0]   opcode_i;
  logic [TASK_W-1:0] task_index_i;
  logic [PRIO_W-1:0] priority_req_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [STAT_W-1:0] status_o;
  logic [TASK_W-1:0] result_task_o;
  logic [PRIO_W-1:0] result_priority_o;
  logic              any_ready_o;

  priority_bitmap_ready_scheduler_unit DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .opcode_i         (opcode_i),
    .task_index_i     (task_index_i),
    .priority_req_i   (priority_req_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .result_task_o    (result_task_o),
    .result_priority_o(result_priority_o),
    .any_ready_o      (any_ready_o)
  );

  always #4 clk_i = ~clk_i;

  // -------------------------------------------------------------------------
  // Scheduler shadow state: per-level ready FIFOs, non-empty bitmap,
  // free list ring and the halt bit.
  // -------------------------------------------------------------------------
  logic [TASK_W-1:0] level_slot [NUM_LEVELS][LEVEL_DEPTH];
  int                level_head [NUM_LEVELS];
  int                level_tail [NUM_LEVELS];
  int                level_count[NUM_LEVELS];
  logic [MAP_W-1:0]  ready_map;
  logic [TASK_W-1:0] free_slot [NUM_TASK_IDS];
  int                free_head;
  int                free_tail;
  int                free_count;
  logic              halt_bit;

  sched_result_t     expected_results[$];
  int                mismatches   = 0;
  int                idle_cycles  = 0;
  bit                quiet_tail   = 1'b0;  // no idling on either side
  bit                hold_off_req = 1'b0;  // ask the receiver for a long stall

  task automatic reset_shadow();
    for (int l = 0; l < NUM_LEVELS; l++) begin
      level_head[l]  = 0;
      level_tail[l]  = 0;
      level_count[l] = 0;
    end
    for (int i = 0; i < NUM_TASK_IDS; i++) begin
      free_slot[i] = TASK_W'(i);  // free list starts full, task i in slot i
    end
    ready_map  = '0;
    free_head  = 0;
    free_tail  = 0;
    free_count = NUM_TASK_IDS;
    halt_bit   = 1'b0;
  endtask

  // Apply one request to the shadow state and return the result it causes.
  function automatic sched_result_t schedule_step(opcode_e op,
                                                  logic [TASK_W-1:0] tid,
                                                  logic [PRIO_W-1:0] lvl);
    sched_result_t r;
    int            l;
    r        = '0;
    r.status = STAT_DONE;
    l        = int'(lvl);
    case (op)
      OP_PUSH: begin
        if (l >= NUM_LEVELS || level_count[l] >= LEVEL_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          level_slot[l][level_tail[l]] = tid;
          level_tail[l] = (level_tail[l] == LEVEL_DEPTH - 1) ? 0 : level_tail[l] + 1;
          level_count[l]++;
          ready_map[l] = 1'b1;
        end
      end
      OP_DISPATCH: begin
        if (ready_map == '0 || halt_bit) begin
          r.status = STAT_EMPTY;
        end else begin
          // level 0 is served first
          l = 0;
          while (l < MAP_W - 1 && !ready_map[l]) l++;
          r.task_id = level_slot[l][level_head[l]];
          r.level   = PRIO_W'(l);
          level_head[l] = (level_head[l] == LEVEL_DEPTH - 1) ? 0 : level_head[l] + 1;
          level_count[l]--;
          if (level_count[l] == 0) ready_map[l] = 1'b0;
        end
      end
      OP_TAKE: begin
        if (free_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.task_id = free_slot[free_head];
          free_head = (free_head == NUM_TASK_IDS - 1) ? 0 : free_head + 1;
          free_count--;
        end
      end
      default: begin  // OP_RETURN
        if (free_count >= NUM_TASK_IDS) begin
          r.status = STAT_FULL;
        end else begin
          free_slot[free_tail] = tid;
          free_tail = (free_tail == NUM_TASK_IDS - 1) ? 0 : free_tail + 1;
          free_count++;
        end
      end
    endcase
    r.any_ready = |ready_map;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Random task index and level, sized to the request fields.
  function automatic logic [TASK_W-1:0] rand_task();
    return TASK_W'($urandom_range(0, NUM_TASK_IDS - 1));
  endfunction

  function automatic logic [PRIO_W-1:0] rand_level();
    return PRIO_W'($urandom_range(0, NUM_LEVELS - 1));
  endfunction

  // -------------------------------------------------------------------------
  // Request side. Inputs change on the falling edge; the transfer is seen
  // on the rising edge. Valid is left high so back-to-back requests keep it
  // high without a drop in between; gaps lower it explicitly.
  // -------------------------------------------------------------------------
  task automatic send_request(opcode_e op, logic [TASK_W-1:0] tid,
                              logic [PRIO_W-1:0] lvl);
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    task_index_i   <= tid;
    priority_req_i <= lvl;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    expected_results.push_back(schedule_step(op, tid, lvl));
  endtask

  task automatic rest_requests(int cycles);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic maybe_gap();
    if (!quiet_tail && $urandom_range(0, 7) == 0) rest_requests($urandom_range(1, 5));
  endtask

  // Sender stops until every outstanding result has been taken, then lets
  // the pipeline settle.
  task automatic drain_results();
    rest_requests(0);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Halt register write; only with the block idle.
  task automatic write_halt(logic value);
    drain_results();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    halt_bit     = value;
  endtask

  task automatic draw_request(mix_e mix, output opcode_e op,
                              output logic [TASK_W-1:0] tid,
                              output logic [PRIO_W-1:0] lvl);
    int pick;
    pick = $urandom_range(0, 99);
    tid  = rand_task();
    lvl  = rand_level();
    case (mix)
      MIX_FILL: begin
        op = (pick < 70) ? OP_PUSH : (pick < 90) ? OP_DISPATCH :
             (pick < 95) ? OP_TAKE : OP_RETURN;
        // mostly the two lowest-priority levels, which fill up fastest
        if ($urandom_range(0, 3) != 0)
          lvl = PRIO_W'($urandom_range(NUM_LEVELS - 2, NUM_LEVELS - 1));
      end
      MIX_DRAIN: begin
        op = (pick < 60) ? OP_DISPATCH : (pick < 85) ? OP_PUSH :
             (pick < 93) ? OP_TAKE : OP_RETURN;
      end
      MIX_FREE: begin
        op = (pick < 45) ? OP_TAKE : (pick < 90) ? OP_RETURN :
             (pick < 95) ? OP_PUSH : OP_DISPATCH;
      end
      default: begin
        op = (pick < 25) ? OP_PUSH : (pick < 50) ? OP_DISPATCH :
             (pick < 75) ? OP_TAKE : OP_RETURN;
      end
    endcase
  endtask

  task automatic run_mix(mix_e mix, int count);
    opcode_e           op;
    logic [TASK_W-1:0] tid;
    logic [PRIO_W-1:0] lvl;
    for (int i = 0; i < count; i++) begin
      draw_request(mix, op, tid, lvl);
      send_request(op, tid, lvl);
      maybe_gap();
    end
  endtask

  // -------------------------------------------------------------------------
  // Result side: random stall bursts, a long hold-off on request, none in
  // the tail of the run.
  // -------------------------------------------------------------------------
  initial begin : result_sink
    int   burst;
    int   hold;
    logic stall;
    burst       = 0;
    hold        = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold         = HOLD_CYCLES;
        hold_off_req = 1'b0;
      end
      stall = 1'b0;
      if (hold > 0) begin
        hold--;
        stall = 1'b1;
      end else if (burst > 0) begin
        burst--;
        stall = 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 5) - 1;
        stall = 1'b1;
      end
      out_stall_i <= stall;
    end
  end

  // In-order check of each result transfer against the oldest expectation.
  always @(posedge clk_i) begin : result_check
    sched_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: status %0d task %0d",
                                  status_o, result_task_o));
      end else begin
        want = expected_results.pop_front();
        if (status_o !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", status_o, want.status));
        if (result_task_o !== want.task_id)
          report_mismatch($sformatf("result_task %0d, want %0d", result_task_o,
                                    want.task_id));
        if (result_priority_o !== want.level)
          report_mismatch($sformatf("result_priority %0d, want %0d", result_priority_o,
                                    want.level));
        if (any_ready_o !== want.any_ready)
          report_mismatch($sformatf("any_ready %0b, want %0b", any_ready_o,
                                    want.any_ready));
      end
    end
  end

  // Watchdog: stretches without any transfer on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("TEST FAILED");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // Corner cases in a short fixed sequence: full free list, empty dispatch,
  // field extremes, priority order, duplicates and dispatch while halted.
  task automatic test_directed();
    send_request(OP_RETURN, 6'h2A, 5'd31);    // free list still full
    send_request(OP_DISPATCH, 6'h3F, 5'd31);  // nothing ready
    send_request(OP_PUSH, 6'h3F, 5'd31);
    send_request(OP_PUSH, 6'h00, 5'd0);
    send_request(OP_PUSH, 6'h15, 5'h15);
    send_request(OP_PUSH, 6'h2A, 5'h0A);
    repeat (4) send_request(OP_DISPATCH, 6'h00, 5'd0);  // levels 0, 10, 21, 31
    send_request(OP_DISPATCH, 6'h15, 5'h0A);            // empty again
    send_request(OP_TAKE, 6'h3F, 5'd31);
    send_request(OP_TAKE, 6'h00, 5'd0);
    send_request(OP_RETURN, 6'h3F, 5'd0);
    send_request(OP_RETURN, 6'h00, 5'd31);
    // same task twice on one level
    send_request(OP_PUSH, 6'h07, 5'd7);
    send_request(OP_PUSH, 6'h07, 5'd7);
    send_request(OP_DISPATCH, 6'h00, 5'd0);
    send_request(OP_DISPATCH, 6'h00, 5'd0);
    // halted: a queued task stays put
    send_request(OP_PUSH, 6'h05, 5'd3);
    write_halt(1'b1);
    send_request(OP_DISPATCH, 6'h00, 5'd0);
    write_halt(1'b0);
    send_request(OP_DISPATCH, 6'h00, 5'd0);
  endtask

  // Empty the free list past its end, then refill it past full with
  // random tasks; both pointers wrap.
  task automatic test_free_list_wrap();
    repeat (NUM_TASK_IDS + 1) begin
      send_request(OP_TAKE, rand_task(), rand_level());
      maybe_gap();
    end
    repeat (NUM_TASK_IDS + 1) begin
      send_request(OP_RETURN, rand_task(), rand_level());
      maybe_gap();
    end
  endtask

  // Fill one level to the brim, overflow it, dispatch while halted, then
  // empty everything.
  task automatic test_ready_queue_full();
    logic [PRIO_W-1:0] lvl;
    lvl = rand_level();
    repeat (LEVEL_DEPTH + 2) begin
      send_request(OP_PUSH, rand_task(), lvl);
      maybe_gap();
    end
    write_halt(1'b1);
    repeat (2) send_request(OP_DISPATCH, rand_task(), lvl);
    write_halt(1'b0);
    repeat (LEVEL_DEPTH + 4) begin
      send_request(OP_DISPATCH, rand_task(), rand_level());
      maybe_gap();
    end
  endtask

  // Receiver holds off for a long stretch while requests keep coming, so
  // the result register and the request port both back up; then the
  // sender waits for every result.
  task automatic test_backpressure();
    hold_off_req = 1'b1;
    run_mix(MIX_BALANCED, 24);
    drain_results();
  endtask

  // Random traffic in several shapes and halt settings.
  task automatic test_random_traffic();
    run_mix(MIX_FILL, 350);
    run_mix(MIX_DRAIN, 250);
    write_halt(1'b1);
    run_mix(MIX_BALANCED, 100);
    write_halt(1'b0);
    run_mix(MIX_BALANCED, 300);
    run_mix(MIX_FREE, 200);
  endtask

  // Back-to-back tail with no idling on either side.
  task automatic test_full_rate();
    drain_results();
    quiet_tail = 1'b1;
    run_mix(MIX_BALANCED, 150);
  endtask

  initial begin : main
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = 1'b0;
    in_valid_i     = 1'b0;
    opcode_i       = OP_PUSH;
    task_index_i   = '0;
    priority_req_i = '0;
    reset_shadow();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_free_list_wrap();
    test_ready_queue_full();
    test_backpressure();
    test_random_traffic();
    test_full_rate();

    drain_results();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
